/* hw/rtl/tilt_pkg.sv */
package tilt_pkg;

    // Raw sample and result widths
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    // CORDIC set-up
    localparam int ITERATIONS = 16;
    localparam int TABLE_LEN  = 24;
    localparam int NUM_ITER   = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

    // Coordinates carry the raw sample times 2^IN_SHIFT; gain and sign need the headroom
    localparam int IN_SHIFT = 14;
    localparam int XY_W     = 34;

    // Angle in degrees times 2^ANG_FRAC, wide enough for the folded range of about +-280 deg
    localparam int ANG_FRAC = 20;
    localparam int ANG_W    = 30;

    // Magnitude times 100 plus rounding constant
    localparam int PROD_W   = ANG_W + 7;

    localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(180 * (1 << ANG_FRAC));
    localparam logic [PROD_W-1:0]       ROUND_HALF   = PROD_W'(1 << (ANG_FRAC - 1));
    localparam logic signed [OUT_W-1:0] CENTI_HALF   = OUT_W'(18000);
    localparam logic signed [OUT_W-1:0] CENTI_QUART  = OUT_W'(9000);
    localparam logic [OUT_W-1:0]        CENTI_LIMIT  = OUT_W'(18000);

    typedef logic signed [XY_W-1:0]  coord_t;
    typedef logic signed [ANG_W-1:0] angle_t;
    typedef logic signed [OUT_W-1:0] centideg_t;

    // Beat that travels through the micro-rotation stages
    typedef struct packed {
        coord_t    x;
        coord_t    y;
        angle_t    a;
        logic      special;
        centideg_t special_val;
        logic      z_neg;
        logic      y_pos;
    } cordic_t;

    // Beat after the half-plane fold
    typedef struct packed {
        angle_t    ang;
        logic      special;
        centideg_t special_val;
    } fold_t;

    // Beat after rounding to centidegrees
    typedef struct packed {
        logic             neg;
        logic [OUT_W-1:0] mag;
        logic             special;
        centideg_t        special_val;
    } round_t;

    // atan(2^-idx) in degrees times 2^ANG_FRAC, rounded to nearest
    function automatic angle_t atan_deg(input int unsigned idx);
        case (idx)
            0:       return ANG_W'(47185920);
            1:       return ANG_W'(27855475);
            2:       return ANG_W'(14718068);
            3:       return ANG_W'(7471121);
            4:       return ANG_W'(3750058);
            5:       return ANG_W'(1876857);
            6:       return ANG_W'(938658);
            7:       return ANG_W'(469357);
            8:       return ANG_W'(234682);
            9:       return ANG_W'(117342);
            10:      return ANG_W'(58671);
            11:      return ANG_W'(29335);
            12:      return ANG_W'(14668);
            13:      return ANG_W'(7334);
            14:      return ANG_W'(3667);
            15:      return ANG_W'(1833);
            16:      return ANG_W'(917);
            17:      return ANG_W'(458);
            18:      return ANG_W'(229);
            19:      return ANG_W'(115);
            20:      return ANG_W'(57);
            21:      return ANG_W'(29);
            22:      return ANG_W'(14);
            23:      return ANG_W'(7);
            default: return '0;
        endcase
    endfunction

endpackage

/* hw/rtl/tilt_in_if.sv */
interface tilt_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tilt_pkg::IN_W-1:0]    accel_y;
    logic signed [tilt_pkg::IN_W-1:0]    accel_z;

    modport source (output valid, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_y, input accel_z, output ready);
endinterface

/* hw/rtl/tilt_out_if.sv */
interface tilt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tilt_pkg::OUT_W-1:0]   tilt_centideg;

    modport source (output valid, output tilt_centideg, input ready);
    modport sink   (input valid, input tilt_centideg, output ready);
endinterface

/* hw/rtl/tilt_angle_atan2.sv */
// Four-quadrant tilt angle atan2(accel_y, accel_z) in signed hundredths of a
// degree, -18000 to 18000, from one pair of raw 16-bit accelerometer samples
// per beat. Raw-count scaling is not needed since it cancels in the ratio. The
// block takes one beat every clock unless the result side stalls it and holds
// no state between beats. Each beat passes through these registers in order:
// the input stage, one register per CORDIC micro-rotation, the half-plane
// fold, the rounding to centidegrees and the output register.
// Every stage has its own valid bit and moves whenever its successor is free,
// so back-pressure on the result side stalls the pipe without losing or
// repeating a beat, and bubbles close up. A zero Y gives 0 (or 18000 for a
// negative Z), a zero Z with nonzero Y gives +-9000.
module tilt_angle_atan2 (
    input  logic        clk,
    input  logic        rst_n,
    tilt_in_if.sink     sample,
    tilt_out_if.source  angle
);

    localparam int IN_W  = tilt_pkg::IN_W;
    localparam int XY_W  = tilt_pkg::XY_W;
    localparam int ANG_W = tilt_pkg::ANG_W;
    localparam int OUT_W = tilt_pkg::OUT_W;
    localparam int SH    = tilt_pkg::IN_SHIFT;

    // ---------------------------------------------------------------
    // Input stage: take |Z| as x, Y as y, flag the trivial cases
    // ---------------------------------------------------------------
    logic              pre_valid_reg;
    tilt_pkg::cordic_t pre_reg;
    tilt_pkg::cordic_t pre_next;
    logic              pre_adv;

    logic              core_in_ready;
    logic              core_out_valid;
    tilt_pkg::cordic_t core_out;

    logic [IN_W:0]     abs_z;
    logic              y_zero;
    logic              z_zero;

    always_comb
    begin
        y_zero = (sample.accel_y == '0);
        z_zero = (sample.accel_z == '0);
        abs_z  = sample.accel_z[IN_W-1] ? ((IN_W+1)'(0) - {1'b1, sample.accel_z})
                                        : {1'b0, sample.accel_z};

        pre_next.x     = {{(XY_W-IN_W-1-SH){1'b0}}, abs_z, {SH{1'b0}}};
        pre_next.y     = {{(XY_W-IN_W-SH){sample.accel_y[IN_W-1]}}, sample.accel_y,
                          {SH{1'b0}}};
        pre_next.a     = '0;
        pre_next.z_neg = sample.accel_z[IN_W-1];
        pre_next.y_pos = !sample.accel_y[IN_W-1];
        pre_next.special = y_zero || z_zero;
        if (y_zero)
            pre_next.special_val = sample.accel_z[IN_W-1] ? tilt_pkg::CENTI_HALF : '0;
        else if (sample.accel_y[IN_W-1])
            pre_next.special_val = -tilt_pkg::CENTI_QUART;
        else
            pre_next.special_val = tilt_pkg::CENTI_QUART;
    end

    // ---------------------------------------------------------------
    // Output-side stages and the ready chain
    // ---------------------------------------------------------------
    logic              fold_valid_reg;
    tilt_pkg::fold_t   fold_reg;
    tilt_pkg::fold_t   fold_next;
    logic              fold_adv;

    logic              rnd_valid_reg;
    tilt_pkg::round_t  rnd_reg;
    tilt_pkg::round_t  rnd_next;
    logic              rnd_adv;

    logic                        out_valid_reg;
    tilt_pkg::centideg_t         out_reg;
    tilt_pkg::centideg_t         out_next;
    logic                        out_adv;

    // Advance a stage when it is empty or the next one advances
    assign out_adv  = !out_valid_reg  || angle.ready;
    assign rnd_adv  = !rnd_valid_reg  || out_adv;
    assign fold_adv = !fold_valid_reg || rnd_adv;
    assign pre_adv  = !pre_valid_reg  || core_in_ready;

    assign sample.ready = pre_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (pre_adv)
            pre_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pre_adv && sample.valid)
            pre_reg <= pre_next;
    end

    // ---------------------------------------------------------------
    // Micro-rotations: angle of (|Z|, Y) in (-100, 100) degrees
    // ---------------------------------------------------------------
    tilt_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_valid_reg),
        .in_ready  (core_in_ready),
        .in_data   (pre_reg),
        .out_valid (core_out_valid),
        .out_ready (fold_adv),
        .out_data  (core_out)
    );

    // ---------------------------------------------------------------
    // Fold into the left half plane when Z is negative
    // ---------------------------------------------------------------
    always_comb
    begin
        fold_next.special     = core_out.special;
        fold_next.special_val = core_out.special_val;
        if (!core_out.z_neg)
            fold_next.ang = core_out.a;
        else if (core_out.y_pos)
            fold_next.ang = tilt_pkg::HALF_TURN - core_out.a;
        else
            fold_next.ang = -tilt_pkg::HALF_TURN - core_out.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_valid_reg <= 1'b0;
        else if (fold_adv)
            fold_valid_reg <= core_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (fold_adv && core_out_valid)
            fold_reg <= fold_next;
    end

    // ---------------------------------------------------------------
    // Round |angle| * 100 / 2^20 half away from zero
    // ---------------------------------------------------------------
    logic [ANG_W-1:0]             ang_mag;
    logic [tilt_pkg::PROD_W-1:0]  ang_wide;
    logic [tilt_pkg::PROD_W-1:0]  prod;

    always_comb
    begin
        ang_mag  = fold_reg.ang[ANG_W-1] ? ANG_W'(-fold_reg.ang) : ANG_W'(fold_reg.ang);
        ang_wide = tilt_pkg::PROD_W'(ang_mag);
        // times 100 = 64 + 32 + 4
        prod = (ang_wide << 6) + (ang_wide << 5) + (ang_wide << 2) + tilt_pkg::ROUND_HALF;

        rnd_next.neg         = fold_reg.ang[ANG_W-1];
        rnd_next.mag         = prod[tilt_pkg::ANG_FRAC +: OUT_W];
        rnd_next.special     = fold_reg.special;
        rnd_next.special_val = fold_reg.special_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_valid_reg <= 1'b0;
        else if (rnd_adv)
            rnd_valid_reg <= fold_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rnd_adv && fold_valid_reg)
            rnd_reg <= rnd_next;
    end

    // ---------------------------------------------------------------
    // Clamp, restore the sign, pick the trivial-case value
    // ---------------------------------------------------------------
    logic [OUT_W-1:0] mag_sat;

    always_comb
    begin
        mag_sat = (rnd_reg.mag > tilt_pkg::CENTI_LIMIT) ? tilt_pkg::CENTI_LIMIT : rnd_reg.mag;
        if (rnd_reg.special)
            out_next = rnd_reg.special_val;
        else if (rnd_reg.neg)
            out_next = -$signed(mag_sat);
        else
            out_next = $signed(mag_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= rnd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && rnd_valid_reg)
            out_reg <= out_next;
    end

    assign angle.valid         = out_valid_reg;
    assign angle.tilt_centideg = out_reg;

endmodule

/* hw/rtl/tilt_cordic.sv */
// Vectoring CORDIC: one registered micro-rotation per stage.
module tilt_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tilt_pkg::cordic_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tilt_pkg::cordic_t out_data
);

    localparam int N = tilt_pkg::NUM_ITER;

    logic              valid_reg  [N];
    tilt_pkg::cordic_t stage_reg  [N];
    tilt_pkg::cordic_t stage_next [N];
    logic              src_valid  [N];
    logic              adv        [N];

    // Rotate toward the x axis by atan(2^-k)
    function automatic tilt_pkg::cordic_t rotate(input tilt_pkg::cordic_t s, input int k);
        tilt_pkg::cordic_t r;
        tilt_pkg::coord_t  dx;
        tilt_pkg::coord_t  dy;
        r  = s;
        dx = s.y >>> k;
        dy = s.x >>> k;
        if (!s.y[tilt_pkg::XY_W-1])
        begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.a = s.a + tilt_pkg::atan_deg(k);
        end
        else
        begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.a = s.a - tilt_pkg::atan_deg(k);
        end
        return r;
    endfunction

    // A stage advances when it is empty or its successor advances
    always_comb
    begin
        for (int k = N - 1; k >= 0; k--)
        begin
            if (k == N - 1)
                adv[k] = !valid_reg[k] || out_ready;
            else
                adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign src_valid[k]  = in_valid;
            assign stage_next[k] = rotate(in_data, k);
        end
        else
        begin : g_rest
            assign src_valid[k]  = valid_reg[k-1];
            assign stage_next[k] = rotate(stage_reg[k-1], k);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv[k])
                valid_reg[k] <= src_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_valid[k])
                stage_reg[k] <= stage_next[k];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[N-1];
    assign out_data  = stage_reg[N-1];

endmodule
